@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file mctt_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MCTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MCTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/mctt_pkg.sv @@
// Types, codes and constants of the MIDI clock tempo tracker.
// No dependencies.
package mctt_pkg;

    localparam int unsigned PULSES_PER_BEAT_DEF = 24;

    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    // divider: 60e6 / divisor, one quotient bit per cycle
    localparam int unsigned DIV_QW = 26;
    localparam int unsigned DIV_DW = 40;
    localparam int unsigned DIV_CW = 5;
    localparam logic [DIV_QW-1:0] MINUTE_US = 26'd60000000;

    localparam logic [2:0] ACT_CLOCK      = 3'd0;
    localparam logic [2:0] ACT_START      = 3'd1;
    localparam logic [2:0] ACT_CONTINUE   = 3'd2;
    localparam logic [2:0] ACT_STOP       = 3'd3;
    localparam logic [2:0] ACT_TIME_CHECK = 3'd4;

    localparam logic [1:0] CFG_MAX_BPM     = 2'd0;
    localparam logic [1:0] CFG_MIN_BPM     = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd2;
    localparam logic [1:0] CFG_SAMPLE_PER  = 2'd3;

    localparam logic [9:0]  MAX_BPM_RST    = 10'd320;
    localparam logic [9:0]  MIN_BPM_RST    = 10'd20;
    localparam logic [31:0] TIMEOUT_RST    = 32'd500000;
    localparam logic [15:0] SAMPLE_PER_RST = 16'd20;

    typedef enum logic [2:0] {
        ST_NORMAL    = 3'd0,
        ST_FIRST     = 3'd1,
        ST_SPURIOUS  = 3'd2,
        ST_GAP       = 3'd3,
        ST_RESYNC    = 3'd4,
        ST_NOT_CLOCK = 3'd5
    } status_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] now_us;
    } in_item_t;

    typedef struct packed {
        logic [47:0] period_smoothed;
        logic [39:0] beat_period_us;
        logic [9:0]  tempo_bpm;
        logic [31:0] tick_count;
        logic [31:0] beats_seen;
        logic        beat_boundary;
        logic [2:0]  ticks_advanced;
        logic        is_playing;
        logic        is_locked;
        status_t     clock_status;
        logic        timed_out;
    } out_item_t;

    typedef struct packed {
        logic [9:0]  max_bpm;
        logic [9:0]  min_bpm;
        logic [31:0] timeout_us;
        logic [15:0] sample_period_us;
    } cfg_t;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quotient;
    } div_res_t;

endpackage

@@ sv/mctt_div.sv @@
// Restoring divider, 60e6 / divisor, one quotient bit per cycle.
// Depends on mctt_pkg.
module mctt_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mctt_pkg::DIV_DW-1:0] divisor,
    output mctt_pkg::div_res_t          res
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [mctt_pkg::DIV_CW-1:0] cnt_reg, cnt_next;
    logic [mctt_pkg::DIV_QW-1:0] num_reg, num_next;
    logic [mctt_pkg::DIV_QW-1:0] quo_reg, quo_next;
    logic [mctt_pkg::DIV_DW-1:0] den_reg, den_next;
    logic [mctt_pkg::DIV_DW-1:0] rem_reg, rem_next;
    logic [mctt_pkg::DIV_DW:0]   trial;
    logic [mctt_pkg::DIV_DW:0]   trial_sub;
    logic                        fits;

    always_comb
    begin
        trial     = {rem_reg, num_reg[mctt_pkg::DIV_QW-1]};
        trial_sub = trial - {1'b0, den_reg};
        fits      = trial >= {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = mctt_pkg::DIV_CW'(mctt_pkg::DIV_QW);
            num_next  = mctt_pkg::MINUTE_US;
            quo_next  = '0;
            den_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[mctt_pkg::DIV_DW-1:0] : trial[mctt_pkg::DIV_DW-1:0];
            quo_next = {quo_reg[mctt_pkg::DIV_QW-2:0], fits};
            num_next = {num_reg[mctt_pkg::DIV_QW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mctt_pkg::DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

@@ sv/mctt_cfg.sv @@
// APB configuration registers of the tempo tracker.
// Depends on mctt_pkg.
module mctt_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mctt_pkg::APB_AW-1:0] paddr,
    input  logic [mctt_pkg::APB_DW-1:0] pwdata,
    output logic [mctt_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output mctt_pkg::cfg_t              cfg
);

    mctt_pkg::cfg_t cfg_reg, cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                mctt_pkg::CFG_MAX_BPM:    cfg_next.max_bpm          = pwdata[9:0];
                mctt_pkg::CFG_MIN_BPM:    cfg_next.min_bpm          = pwdata[9:0];
                mctt_pkg::CFG_TIMEOUT:    cfg_next.timeout_us       = pwdata;
                mctt_pkg::CFG_SAMPLE_PER: cfg_next.sample_period_us = pwdata[15:0];
                default:                  cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            mctt_pkg::CFG_MAX_BPM:    prdata = 32'(cfg_reg.max_bpm);
            mctt_pkg::CFG_MIN_BPM:    prdata = 32'(cfg_reg.min_bpm);
            mctt_pkg::CFG_TIMEOUT:    prdata = cfg_reg.timeout_us;
            mctt_pkg::CFG_SAMPLE_PER: prdata = 32'(cfg_reg.sample_period_us);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_bpm          <= mctt_pkg::MAX_BPM_RST;
            cfg_reg.min_bpm          <= mctt_pkg::MIN_BPM_RST;
            cfg_reg.timeout_us       <= mctt_pkg::TIMEOUT_RST;
            cfg_reg.sample_period_us <= mctt_pkg::SAMPLE_PER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/midi_clock_tempo_tracker_core.sv @@
// Clock transaction: a pass through the shared divider for the min interval and a second
// pass for the tempo when the beat period is updated; other actions skip the divider.
// Throughput: one transaction at a time; item_stall is high until the sequencer
// returns to idle. A result waiting on result_stall does not block the next accept.
// Reset: asynchronous active-low; clears tracker state, config to defaults.
// Depends on mctt_pkg, mctt_div, mctt_cfg.
module midi_clock_tempo_tracker_core #(
    parameter int unsigned PULSES_PER_BEAT = mctt_pkg::PULSES_PER_BEAT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  mctt_pkg::in_item_t          item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output mctt_pkg::out_item_t         result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mctt_pkg::APB_AW-1:0] paddr,
    input  logic [mctt_pkg::APB_DW-1:0] pwdata,
    output logic [mctt_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int unsigned PPBW = $clog2(PULSES_PER_BEAT + 1);
    localparam int unsigned MW   = 10 + PPBW;
    localparam int unsigned PW   = 48 + PPBW;
    localparam int unsigned BW   = PW - 8;
    localparam int unsigned PSW  = $clog2(2 * PULSES_PER_BEAT + 5);
    localparam longint unsigned TICK_SPAN = 64'h1_0000_0000;
    localparam int unsigned WRAP_ADJ =
        PULSES_PER_BEAT - int'(TICK_SPAN % PULSES_PER_BEAT);

    typedef enum logic [13:0] {
        S_IDLE   = 14'h0001,
        S_DIFF   = 14'h0002,
        S_DIVMIN = 14'h0004,
        S_CHECK  = 14'h0008,
        S_DELTA  = 14'h0010,
        S_SMOOTH = 14'h0020,
        S_MUL    = 14'h0040,
        S_APPLY  = 14'h0080,
        S_DIVBPM = 14'h0100,
        S_TICK   = 14'h0200,
        S_ADV    = 14'h0400,
        S_COUNT  = 14'h0800,
        S_MISC   = 14'h1000,
        S_DONE   = 14'h2000
    } state_t;

    mctt_pkg::cfg_t     cfg;
    mctt_pkg::div_res_t div_res;
    logic               div_start;
    logic [mctt_pkg::DIV_DW-1:0] div_divisor;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    mctt_pkg::out_item_t result_reg, result_next;

    // tracker state
    logic [63:0]    last_reg, last_next;
    logic [47:0]    smooth_reg, smooth_next;
    logic [39:0]    period_reg, period_next;
    logic [9:0]     bpm_reg, bpm_next;
    logic [31:0]    tick_reg, tick_next;
    logic [31:0]    beat_reg, beat_next;
    logic [PSW-1:0] phase_reg, phase_next;
    logic           playing_reg, playing_next;
    logic           pending_reg, pending_next;
    logic           locked_reg, locked_next;

    // per-transaction working registers
    logic [2:0]        action_reg, action_next;
    logic [63:0]       now_reg, now_next;
    logic [63:0]       diff_reg, diff_next;
    logic              borrow_reg, borrow_next;
    logic [mctt_pkg::DIV_QW-1:0] min_iv_reg, min_iv_next;
    logic [47:0]       prev_reg, prev_next;
    logic [47:0]       dlt_reg, dlt_next;
    logic              up_reg, up_next;
    logic [BW-1:0]     bp_raw_reg, bp_raw_next;
    logic [1:0]        adv_idx_reg, adv_idx_next;
    logic [2:0]        ticks_reg, ticks_next;
    mctt_pkg::status_t status_reg, status_next;
    logic              bnd_reg, bnd_next;
    logic              tout_reg, tout_next;

    // datapath terms
    logic [64:0]    sub65;
    logic [9:0]     bpm_floor1;
    logic [MW-1:0]  min_div;
    logic [47:0]    v_val;
    logic [PW-1:0]  bp_prod;
    logic [39:0]    bp_sat;
    logic [mctt_pkg::DIV_QW-1:0] bpm_lo;
    logic [2:0]     factor;
    logic [50:0]    x_val;
    logic [50:0]    thr;
    logic [32:0]    tick_sum;
    logic [PSW-1:0] ph_sum;

    mctt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mctt_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (div_divisor),
        .res     (div_res)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        sub65      = {1'b0, now_reg} - {1'b0, last_reg};
        bpm_floor1 = (cfg.max_bpm == 10'd0) ? 10'd1 : cfg.max_bpm;
        min_div    = MW'(bpm_floor1) * MW'(PULSES_PER_BEAT);
        v_val      = (|diff_reg[63:40]) ? 48'hFFFF_FFFF_FFFF : {diff_reg[39:0], 8'h00};
        bp_prod    = PW'(smooth_reg) * PW'(PULSES_PER_BEAT);
        bp_sat     = (|bp_raw_reg[BW-1:40]) ? 40'hFF_FFFF_FFFF : bp_raw_reg[39:0];
        bpm_lo     = (div_res.quotient < mctt_pkg::DIV_QW'(cfg.min_bpm)) ?
                     mctt_pkg::DIV_QW'(cfg.min_bpm) : div_res.quotient;
        factor     = {adv_idx_reg, 1'b1} + 3'd2;
        x_val      = {diff_reg[41:0], 9'b0};
        thr        = 51'(prev_reg) * 51'(factor);
        tick_sum   = {1'b0, tick_reg} + 33'(ticks_reg);
        ph_sum     = PSW'(phase_reg) + PSW'(ticks_reg) +
                     (tick_sum[32] ? PSW'(WRAP_ADJ) : PSW'(0));
        for (int i = 0; i < 6; i++)
        begin
            if (ph_sum >= PSW'(PULSES_PER_BEAT))
            begin
                ph_sum = ph_sum - PSW'(PULSES_PER_BEAT);
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        last_next         = last_reg;
        smooth_next       = smooth_reg;
        period_next       = period_reg;
        bpm_next          = bpm_reg;
        tick_next         = tick_reg;
        beat_next         = beat_reg;
        phase_next        = phase_reg;
        playing_next      = playing_reg;
        pending_next      = pending_reg;
        locked_next       = locked_reg;
        action_next       = action_reg;
        now_next          = now_reg;
        diff_next         = diff_reg;
        borrow_next       = borrow_reg;
        min_iv_next       = min_iv_reg;
        prev_next         = prev_reg;
        dlt_next          = dlt_reg;
        up_next           = up_reg;
        bp_raw_next       = bp_raw_reg;
        adv_idx_next      = adv_idx_reg;
        ticks_next        = ticks_reg;
        status_next       = status_reg;
        bnd_next          = bnd_reg;
        tout_next         = tout_reg;
        div_start         = 1'b0;
        div_divisor       = mctt_pkg::DIV_DW'(min_div);

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    action_next = item.action;
                    now_next    = item.now_us;
                    state_next  = S_DIFF;
                end
            end

            S_DIFF:
            begin
                diff_next   = sub65[63:0];
                borrow_next = sub65[64];
                ticks_next  = 3'd0;
                bnd_next    = 1'b0;
                tout_next   = 1'b0;
                status_next = mctt_pkg::ST_NOT_CLOCK;
                if (action_reg == mctt_pkg::ACT_CLOCK)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVMIN;
                end
                else
                begin
                    state_next = S_MISC;
                end
            end

            S_DIVMIN:
            begin
                if (div_res.done)
                begin
                    min_iv_next = div_res.quotient;
                    state_next  = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (last_reg == 64'd0)
                begin
                    status_next = mctt_pkg::ST_FIRST;
                    prev_next   = '0;
                    state_next  = S_TICK;
                end
                else if (diff_reg < 64'(min_iv_reg))
                begin
                    status_next = mctt_pkg::ST_SPURIOUS;
                    state_next  = S_DONE;
                end
                else if (smooth_reg != 48'd0 && diff_reg > 64'(smooth_reg[47:6]))
                begin
                    smooth_next = '0;
                    tick_next   = '0;
                    phase_next  = '0;
                    last_next   = now_reg;
                    status_next = mctt_pkg::ST_GAP;
                    state_next  = S_DONE;
                end
                else
                begin
                    prev_next  = smooth_reg;
                    state_next = S_DELTA;
                end
            end

            S_DELTA:
            begin
                up_next = (v_val >= smooth_reg);
                if (smooth_reg == 48'd0)
                begin
                    dlt_next = v_val;
                end
                else if (v_val >= smooth_reg)
                begin
                    dlt_next = v_val - smooth_reg;
                end
                else
                begin
                    dlt_next = smooth_reg - v_val;
                end
                state_next = S_SMOOTH;
            end

            S_SMOOTH:
            begin
                if (prev_reg == 48'd0)
                begin
                    smooth_next = dlt_reg;
                end
                else if (up_reg)
                begin
                    smooth_next = smooth_reg + {2'b00, dlt_reg[47:2]};
                end
                else
                begin
                    smooth_next = smooth_reg - {2'b00, dlt_reg[47:2]};
                end
                locked_next = 1'b1;
                status_next = mctt_pkg::ST_NORMAL;
                state_next  = S_MUL;
            end

            S_MUL:
            begin
                bp_raw_next = BW'(bp_prod >> 8);
                state_next  = S_APPLY;
            end

            S_APPLY:
            begin
                if (bp_raw_reg != '0 && bp_raw_reg >= BW'(cfg.sample_period_us))
                begin
                    period_next = bp_sat;
                    div_divisor = bp_sat;
                    div_start   = 1'b1;
                    state_next  = S_DIVBPM;
                end
                else
                begin
                    state_next = S_TICK;
                end
            end

            S_DIVBPM:
            begin
                if (div_res.done)
                begin
                    bpm_next   = (bpm_lo > mctt_pkg::DIV_QW'(cfg.max_bpm)) ?
                                 cfg.max_bpm : bpm_lo[9:0];
                    state_next = S_TICK;
                end
            end

            S_TICK:
            begin
                last_next = now_reg;
                if (playing_reg && pending_reg)
                begin
                    pending_next = 1'b0;
                    tick_next    = '0;
                    beat_next    = '0;
                    phase_next   = '0;
                    status_next  = mctt_pkg::ST_RESYNC;
                    state_next   = S_DONE;
                end
                else
                begin
                    ticks_next   = 3'd1;
                    adv_idx_next = 2'd0;
                    state_next   = (prev_reg != 48'd0 && diff_reg != 64'd0) ? S_ADV : S_COUNT;
                end
            end

            S_ADV:
            begin
                if (x_val >= thr)
                begin
                    ticks_next = 3'(adv_idx_reg) + 3'd2;
                end
                adv_idx_next = adv_idx_reg + 2'd1;
                if (adv_idx_reg == 2'd2)
                begin
                    state_next = S_COUNT;
                end
            end

            S_COUNT:
            begin
                tick_next  = tick_sum[31:0];
                phase_next = ph_sum;
                if (PSW'(phase_reg) + PSW'(ticks_reg) >= PSW'(PULSES_PER_BEAT))
                begin
                    bnd_next  = 1'b1;
                    beat_next = beat_reg + 32'd1;
                end
                state_next = S_DONE;
            end

            S_MISC:
            begin
                case (action_reg)
                    mctt_pkg::ACT_START:
                    begin
                        playing_next = 1'b1;
                        pending_next = 1'b1;
                        tick_next    = '0;
                        beat_next    = '0;
                        phase_next   = '0;
                        locked_next  = 1'b1;
                    end
                    mctt_pkg::ACT_CONTINUE:
                    begin
                        playing_next = 1'b1;
                        locked_next  = 1'b1;
                    end
                    mctt_pkg::ACT_STOP:
                    begin
                        playing_next = 1'b0;
                        locked_next  = 1'b1;
                    end
                    mctt_pkg::ACT_TIME_CHECK:
                    begin
                        if (last_reg != 64'd0 && !borrow_reg &&
                            diff_reg > 64'(cfg.timeout_us))
                        begin
                            last_next    = '0;
                            smooth_next  = '0;
                            playing_next = 1'b0;
                            locked_next  = 1'b0;
                            tout_next    = 1'b1;
                        end
                    end
                    default:
                    begin
                        playing_next = playing_reg;
                    end
                endcase
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.period_smoothed = smooth_reg;
                    result_next.beat_period_us  = period_reg;
                    result_next.tempo_bpm       = bpm_reg;
                    result_next.tick_count      = tick_reg;
                    result_next.beats_seen      = beat_reg;
                    result_next.beat_boundary   = bnd_reg;
                    result_next.ticks_advanced  = ticks_reg;
                    result_next.is_playing      = playing_reg;
                    result_next.is_locked       = locked_reg;
                    result_next.clock_status    = status_reg;
                    result_next.timed_out       = tout_reg;
                    result_valid_next           = 1'b1;
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            last_reg         <= '0;
            smooth_reg       <= '0;
            period_reg       <= '0;
            bpm_reg          <= '0;
            tick_reg         <= '0;
            beat_reg         <= '0;
            phase_reg        <= '0;
            playing_reg      <= 1'b0;
            pending_reg      <= 1'b0;
            locked_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            last_reg         <= last_next;
            smooth_reg       <= smooth_next;
            period_reg       <= period_next;
            bpm_reg          <= bpm_next;
            tick_reg         <= tick_next;
            beat_reg         <= beat_next;
            phase_reg        <= phase_next;
            playing_reg      <= playing_next;
            pending_reg      <= pending_next;
            locked_reg       <= locked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg  <= result_next;
        action_reg  <= action_next;
        now_reg     <= now_next;
        diff_reg    <= diff_next;
        borrow_reg  <= borrow_next;
        min_iv_reg  <= min_iv_next;
        prev_reg    <= prev_next;
        dlt_reg     <= dlt_next;
        up_reg      <= up_next;
        bp_raw_reg  <= bp_raw_next;
        adv_idx_reg <= adv_idx_next;
        ticks_reg   <= ticks_next;
        status_reg  <= status_next;
        bnd_reg     <= bnd_next;
        tout_reg    <= tout_next;
    end

endmodule

@@ sv/mctt_checker.sv @@
// Port-level checks of the tempo tracker, bound to the top level.
// Depends on mctt_pkg, assert_macros.svh, midi_clock_tempo_tracker_core.
`include "assert_macros.svh"

module mctt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input logic                result_valid,
    input logic                result_stall,
    input mctt_pkg::out_item_t result
);

    `MCTT_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))
    `MCTT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, item_valid && !item_stall, item_stall)
    `MCTT_ASSERT_IMP(a_timeout_clears, clk, rst_n, result_valid && result.timed_out, !result.is_playing && !result.is_locked && result.period_smoothed == 48'd0)
    `MCTT_ASSERT_IMP(a_ticks_status, clk, rst_n, result_valid, (result.clock_status == mctt_pkg::ST_NORMAL || result.clock_status == mctt_pkg::ST_FIRST) == (result.ticks_advanced != 3'd0))

endmodule

bind midi_clock_tempo_tracker_core mctt_checker u_mctt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
